@@ rtl/core/pixel_blend_mode_unit_macros.svh @@
// assertion macros for the pixel blend mode unit checker
`ifndef PIXEL_BLEND_MODE_UNIT_MACROS_SVH
`define PIXEL_BLEND_MODE_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PBM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("pbm implication check failed");

// next-cycle implication, disabled while in reset
`define PBM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("pbm next-cycle check failed");

`endif

@@ rtl/core/pbm_pkg.sv @@
// shared codes, constants and pipeline types of the pixel blend mode unit
package pbm_pkg;

    localparam logic [3:0] MODE_ALPHA      = 4'd0;
    localparam logic [3:0] MODE_ADD        = 4'd1;
    localparam logic [3:0] MODE_DARKEST    = 4'd2;
    localparam logic [3:0] MODE_LIGHTEST   = 4'd3;
    localparam logic [3:0] MODE_DIFFERENCE = 4'd4;
    localparam logic [3:0] MODE_EXCLUSION  = 4'd5;
    localparam logic [3:0] MODE_MULTIPLY   = 4'd6;
    localparam logic [3:0] MODE_SCREEN     = 4'd7;
    localparam logic [3:0] MODE_OVERLAY    = 4'd8;
    localparam logic [3:0] MODE_HARDLIGHT  = 4'd9;
    localparam logic [3:0] MODE_DODGE      = 4'd10;
    localparam logic [3:0] MODE_BURN       = 4'd11;
    localparam logic [3:0] MODE_SUBTRACT   = 4'd12;

    localparam logic [7:0] OPAQUE_LIMIT = 8'd254;
    localparam logic [7:0] HALF_LEVEL   = 8'd128;
    localparam logic [7:0] CHAN_MAX     = 8'd255;
    localparam logic [7:0] ALPHA_FULL   = 8'hFF;

    localparam int NUM_CHAN       = 3;
    localparam int DIV_STEPS      = 4;

    // per-word control carried down the pipe
    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  alpha;
        logic [31:0] src;
    } ctl_t;

    // per-channel working state
    typedef struct packed {
        logic [7:0]         s;
        logic [7:0]         d;
        logic signed [9:0]  x;
        logic               dv;
        logic [7:0]         rem;
        logic [7:0]         divisor;
        logic [7:0]         quo;
        logic signed [19:0] prod;
    } chan_t;

    typedef chan_t [NUM_CHAN-1:0] pix_t;

endpackage

@@ rtl/core/pbm_value.sv @@
// per-channel mode value and quotient setup for dodge and burn
module pbm_value
(
    input  logic [3:0]    mode,
    input  logic [7:0]    s,
    input  logic [7:0]    d,
    output pbm_pkg::chan_t ch
);

    logic [7:0]  s_inv;
    logic [7:0]  d_inv;
    logic [15:0] p_sd;
    logic [15:0] p_inv;

    // the two products shared by the multiplicative modes
    assign s_inv = pbm_pkg::CHAN_MAX - s;
    assign d_inv = pbm_pkg::CHAN_MAX - d;
    assign p_sd  = s * d;
    assign p_inv = s_inv * d_inv;

    // channel value per mode
    always_comb
    begin
        ch         = '0;
        ch.s       = s;
        ch.d       = d;
        ch.x       = $signed({2'b00, s});
        ch.dv      = 1'b0;
        ch.rem     = 8'd0;
        ch.divisor = 8'd0;
        ch.quo     = 8'd0;
        ch.prod    = '0;
        case (mode)
            pbm_pkg::MODE_ADD:
                ch.x = $signed({2'b00, s}) + $signed({2'b00, d});
            pbm_pkg::MODE_DARKEST:
                ch.x = $signed({2'b00, (s < d) ? s : d});
            pbm_pkg::MODE_LIGHTEST:
                ch.x = $signed({2'b00, (s > d) ? s : d});
            pbm_pkg::MODE_DIFFERENCE:
                ch.x = $signed({2'b00, (s >= d) ? (s - d) : (d - s)});
            pbm_pkg::MODE_EXCLUSION:
                ch.x = $signed({2'b00, s}) + $signed({2'b00, d})
                     - $signed({1'b0, p_sd[15:7]});
            pbm_pkg::MODE_MULTIPLY:
                ch.x = $signed({2'b00, p_sd[15:8]});
            pbm_pkg::MODE_SCREEN:
                ch.x = $signed({2'b00, pbm_pkg::CHAN_MAX - p_inv[15:8]});
            pbm_pkg::MODE_OVERLAY:
                ch.x = (d < pbm_pkg::HALF_LEVEL) ? $signed({1'b0, p_sd[15:7]})
                     : $signed({2'b00, pbm_pkg::CHAN_MAX})
                       - $signed({1'b0, p_inv[15:7]});
            pbm_pkg::MODE_HARDLIGHT:
                ch.x = (s < pbm_pkg::HALF_LEVEL) ? $signed({1'b0, p_sd[15:7]})
                     : $signed({2'b00, pbm_pkg::CHAN_MAX})
                       - $signed({1'b0, p_inv[15:7]});
            pbm_pkg::MODE_DODGE:
            begin
                ch.rem     = d;
                ch.divisor = s_inv;
                if (s >= pbm_pkg::OPAQUE_LIMIT)
                    ch.x = $signed({2'b00, s});
                else if (d >= s_inv)
                    ch.x = $signed({2'b00, pbm_pkg::CHAN_MAX});
                else
                    ch.dv = 1'b1;
            end
            pbm_pkg::MODE_BURN:
            begin
                ch.rem     = d_inv;
                ch.divisor = s;
                ch.x       = 10'sd0;
                if (s != 8'd0 && d_inv < s)
                    ch.dv = 1'b1;
            end
            pbm_pkg::MODE_SUBTRACT:
                ch.x = $signed({2'b00, s}) + $signed({2'b00, d})
                     - $signed({2'b00, pbm_pkg::CHAN_MAX});
            default:
                ch.x = $signed({2'b00, s});
        endcase
    end

endmodule

@@ rtl/core/pbm_div_step.sv @@
// four restoring division steps per channel for the dodge and burn quotient
module pbm_div_step
(
    input  pbm_pkg::pix_t pix_in,
    output pbm_pkg::pix_t pix_out
);

    // shift in a zero, subtract the divisor when it fits
    always_comb
    begin
        logic [8:0] r2;
        pix_out = pix_in;
        r2      = '0;
        for (int c = 0; c < pbm_pkg::NUM_CHAN; c++)
        begin
            for (int k = 0; k < pbm_pkg::DIV_STEPS; k++)
            begin
                r2 = {pix_out[c].rem, 1'b0};
                if (r2 >= {1'b0, pix_out[c].divisor})
                begin
                    r2 = r2 - {1'b0, pix_out[c].divisor};
                    pix_out[c].quo = {pix_out[c].quo[6:0], 1'b1};
                end
                else
                begin
                    pix_out[c].quo = {pix_out[c].quo[6:0], 1'b0};
                end
                pix_out[c].rem = r2[7:0];
            end
        end
    end

endmodule

@@ rtl/core/pbm_mix.sv @@
// resolves dodge and burn values and forms the alpha-weighted difference product
module pbm_mix
(
    input  pbm_pkg::ctl_t ctl,
    input  pbm_pkg::pix_t pix_in,
    output pbm_pkg::pix_t pix_out
);

    always_comb
    begin
        logic signed [9:0]  base;
        logic signed [10:0] diff;
        pix_out = pix_in;
        base    = '0;
        diff    = '0;
        for (int c = 0; c < pbm_pkg::NUM_CHAN; c++)
        begin
            // quotient turns into the channel value
            if (pix_in[c].dv)
            begin
                if (ctl.mode == pbm_pkg::MODE_DODGE)
                    pix_out[c].x = $signed({2'b00, pix_in[c].quo});
                else
                    pix_out[c].x = $signed({2'b00, pbm_pkg::CHAN_MAX - pix_in[c].quo});
            end
            // (value - dest) * alpha
            base = (ctl.mode == pbm_pkg::MODE_ALPHA) ? $signed({2'b00, pix_in[c].s})
                                                     : pix_out[c].x;
            diff = {base[9], base} - $signed({3'b000, pix_in[c].d});
            pix_out[c].prod = diff * $signed({1'b0, ctl.alpha});
        end
    end

endmodule

@@ rtl/core/pbm_finish.sv @@
// final shift, clamp and packing of the output word
module pbm_finish
(
    input  pbm_pkg::ctl_t ctl,
    input  pbm_pkg::pix_t pix_in,
    output logic [31:0]   result
);

    logic [7:0]  chan_out [pbm_pkg::NUM_CHAN];
    logic        opaque;

    assign opaque = (ctl.alpha >= pbm_pkg::OPAQUE_LIMIT);

    // per-channel shift and clamp
    always_comb
    begin
        logic signed [20:0] sum;
        logic signed [12:0] v;
        sum = '0;
        v   = '0;
        for (int c = 0; c < pbm_pkg::NUM_CHAN; c++)
        begin
            sum = {pix_in[c].prod[19], pix_in[c].prod}
                + $signed({5'b00000, ({pix_in[c].d, 8'd0} - {8'd0, pix_in[c].d})});
            if (ctl.mode == pbm_pkg::MODE_ALPHA)
                v = $signed(13'(pix_in[c].prod >>> 8)) + $signed({5'b00000, pix_in[c].d});
            else if (opaque)
                v = 13'(pix_in[c].x);
            else
                v = 13'(sum >>> 8);
            if (ctl.mode == pbm_pkg::MODE_ADD && v > 13'sd255)
                v = 13'sd255;
            if (ctl.mode == pbm_pkg::MODE_EXCLUSION)
            begin
                if (v < 13'sd0)
                    v = 13'sd0;
                else if (v > 13'sd255)
                    v = 13'sd255;
            end
            if (ctl.mode == pbm_pkg::MODE_SUBTRACT && v < 13'sd0)
                v = 13'sd0;
            chan_out[c] = v[7:0];
        end
    end

    // word assembly
    always_comb
    begin
        if (ctl.mode > pbm_pkg::MODE_SUBTRACT)
            result = {pbm_pkg::ALPHA_FULL, pix_in[2].d, pix_in[1].d, pix_in[0].d};
        else if (ctl.mode == pbm_pkg::MODE_ALPHA && opaque)
            result = ctl.src;
        else
            result = {pbm_pkg::ALPHA_FULL, chan_out[2], chan_out[1], chan_out[0]};
    end

endmodule

@@ rtl/core/pixel_blend_mode_unit.sv @@
// top level of the pixel blend mode unit: pipeline registers and handshake
// Pixel blend mode unit.
// Input channel: in_valid / in_stall with src_argb (ARGB) and dest_rgb (RGB).
// A word is taken at a clock edge where in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with result_argb, taken the same way.
// cfg_we / cfg_wdata write the 4-bit blend mode; write it only while idle.
// Each word is blended per channel in the mode held at the time it enters.
// Six registers, in order: input register, mode value and products, two
// 4-bit quotient stages, weighted product, output register; out_valid rises
// as the word reaches the output register. Throughput: one word per clock
// while the receiver does not stall, set by the fully pipelined divider and multipliers.
// When the receiver stalls with a word waiting, the whole pipe holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears the blend mode to alpha and empties all pipeline stages.
module pixel_blend_mode_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] src_argb,
    input  logic [23:0] dest_rgb,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_argb
);

    logic [3:0]     blend_mode_reg;
    logic [5:0]     valid_reg;
    logic [5:0]     valid_next;
    logic           advance;

    logic [31:0]    src0_reg;
    logic [23:0]    dst0_reg;
    logic [3:0]     mode0_reg;

    pbm_pkg::ctl_t  ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    pbm_pkg::pix_t  pix1_reg, pix2_reg, pix3_reg, pix4_reg;
    pbm_pkg::pix_t  pix1_next, pix2_next, pix3_next, pix4_next;
    pbm_pkg::ctl_t  ctl1_next;
    logic [31:0]    result_reg;
    logic [31:0]    result_next;

    // pipe holds only when the output word is refused
    assign advance    = !(valid_reg[5] && out_stall);
    assign in_stall   = !advance;
    assign out_valid  = valid_reg[5];
    assign result_argb = result_reg;
    assign valid_next = {valid_reg[4:0], in_valid};

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blend_mode_reg <= pbm_pkg::MODE_ALPHA;
        else if (cfg_we)
            blend_mode_reg <= cfg_wdata;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= valid_next;
    end

    // stage 1: mode values and quotient setup
    assign ctl1_next.mode  = mode0_reg;
    assign ctl1_next.alpha = src0_reg[31:24];
    assign ctl1_next.src   = src0_reg;

    for (genvar c = 0; c < pbm_pkg::NUM_CHAN; c++)
    begin : g_value
        pbm_value u_value
        (
            .mode (mode0_reg),
            .s    (src0_reg[8*c +: 8]),
            .d    (dst0_reg[8*c +: 8]),
            .ch   (pix1_next[c])
        );
    end

    // stages 2 and 3: quotient bits, four per stage
    pbm_div_step u_div_hi
    (
        .pix_in  (pix1_reg),
        .pix_out (pix2_next)
    );

    pbm_div_step u_div_lo
    (
        .pix_in  (pix2_reg),
        .pix_out (pix3_next)
    );

    // stage 4: weighted product
    pbm_mix u_mix
    (
        .ctl     (ctl3_reg),
        .pix_in  (pix3_reg),
        .pix_out (pix4_next)
    );

    // stage 5: final value
    pbm_finish u_finish
    (
        .ctl     (ctl4_reg),
        .pix_in  (pix4_reg),
        .result  (result_next)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            src0_reg   <= src_argb;
            dst0_reg   <= dest_rgb;
            mode0_reg  <= blend_mode_reg;
            ctl1_reg   <= ctl1_next;
            pix1_reg   <= pix1_next;
            ctl2_reg   <= ctl1_reg;
            pix2_reg   <= pix2_next;
            ctl3_reg   <= ctl2_reg;
            pix3_reg   <= pix3_next;
            ctl4_reg   <= ctl3_reg;
            pix4_reg   <= pix4_next;
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/core/pbm_checker.sv @@
// port-level checks of the pixel blend mode unit, bound to the top level
`include "pixel_blend_mode_unit_macros.svh"

module pbm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_argb
);

    // a refused word stays offered and unchanged
    `PBM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `PBM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(result_argb))

    // input stalls only behind a refused output word
    `PBM_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `PBM_ASSERT_IMPLY(a_no_idle_stall, clk, rst_n, !(out_valid && out_stall), !in_stall)

endmodule

bind pixel_blend_mode_unit pbm_checker u_pbm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_argb (result_argb)
);
